@@ sv/rbst_pkg.sv @@
// ---------------------------------------------------------------------------
// rbst_pkg
// shared constants for the ray versus box slab test
// ---------------------------------------------------------------------------
package rbst_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int NUM_REGS = 6;
    localparam int IDX_BITS = 3;

    localparam logic [IDX_BITS-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_MAX_Z = 3'd5;

endpackage

@@ sv/rbst_div.sv @@
// ---------------------------------------------------------------------------
// rbst_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module rbst_div #(
    parameter int DW = 48,
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic [DW-1:0] o_quo,
    output logic [SW-1:0] o_sb
);

    logic [VW-1:0] r_a  [DW];
    logic [DW-1:0] r_q  [DW];
    logic [VW-1:0] r_d  [DW];
    logic [SW-1:0] r_sb [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [VW-1:0] a_in;
        logic [DW-1:0] q_in;
        logic [VW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [VW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_in = '0;
            assign q_in = i_num;
            assign d_in = i_den;
            assign s_in = i_sb;
        end else begin : g_next
            assign a_in = r_a[k-1];
            assign q_in = r_q[k-1];
            assign d_in = r_d[k-1];
            assign s_in = r_sb[k-1];
        end

        assign t  = {a_in, q_in[DW-1]};
        assign ge = t >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]  <= ge ? VW'(t - {1'b0, d_in}) : t[VW-1:0];
                r_q[k]  <= {q_in[DW-2:0], ge};
                r_d[k]  <= d_in;
                r_sb[k] <= s_in;
            end
        end
    end

    assign o_quo = r_q[DW-1];
    assign o_sb  = r_sb[DW-1];

endmodule

@@ sv/rbst_lane.sv @@
// ---------------------------------------------------------------------------
// rbst_lane
// one axis: slab distances, two dividers, saturation and ordering
// ---------------------------------------------------------------------------
module rbst_lane #(
    parameter int CB = rbst_pkg::COORD_BITS,
    parameter int FB = rbst_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_org,
    input  logic signed [CB-1:0] i_dir,
    input  logic signed [CB-1:0] i_bmin,
    input  logic signed [CB-1:0] i_bmax,
    output logic signed [CB-1:0] o_tn,
    output logic signed [CB-1:0] o_tf,
    output logic                 o_miss
);

    localparam int DW = CB + FB;
    localparam logic [DW-1:0] LIM_NEG = {{(DW-CB){1'b0}}, 1'b1, {(CB-1){1'b0}}};
    localparam logic [DW-1:0] LIM_POS = LIM_NEG - 1'b1;
    localparam logic signed [CB-1:0] T_LOW  = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] T_HIGH = {1'b0, {(CB-1){1'b1}}};

    logic signed [CB:0] dn_min, dn_max;
    logic [CB-1:0]      nm_min, nm_max, dmag;
    logic               dneg, neg_min, neg_max, zero, in_slab;
    logic [DW-1:0]      q_min, q_max;
    logic [2:0]         sb_min;
    logic               sb_max;
    logic signed [CB-1:0] t_a, t_b;

    function automatic logic signed [CB-1:0] sat(input logic [DW-1:0] q, input logic neg);
        logic [DW-1:0] lim;
        logic [CB-1:0] m;
        lim = neg ? LIM_NEG : LIM_POS;
        m   = (q > lim) ? lim[CB-1:0] : q[CB-1:0];
        return neg ? $signed(CB'(~m + 1'b1)) : $signed(m);
    endfunction

    always_comb begin
        dn_min  = $signed({i_bmin[CB-1], i_bmin}) - $signed({i_org[CB-1], i_org});
        dn_max  = $signed({i_bmax[CB-1], i_bmax}) - $signed({i_org[CB-1], i_org});
        nm_min  = dn_min[CB] ? CB'(-dn_min) : dn_min[CB-1:0];
        nm_max  = dn_max[CB] ? CB'(-dn_max) : dn_max[CB-1:0];
        dneg    = i_dir[CB-1];
        dmag    = dneg ? CB'(-i_dir) : i_dir;
        neg_min = dn_min[CB] ^ dneg;
        neg_max = dn_max[CB] ^ dneg;
        zero    = i_dir == '0;
        in_slab = !(i_org < i_bmin) && !(i_org > i_bmax);
    end

    rbst_div #(.DW(DW), .VW(CB), .SW(3)) u_div_min (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({nm_min, {FB{1'b0}}}),
        .i_den (dmag),
        .i_sb  ({neg_min, zero, in_slab}),
        .o_quo (q_min),
        .o_sb  (sb_min)
    );

    rbst_div #(.DW(DW), .VW(CB), .SW(1)) u_div_max (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({nm_max, {FB{1'b0}}}),
        .i_den (dmag),
        .i_sb  (neg_max),
        .o_quo (q_max),
        .o_sb  (sb_max)
    );

    assign t_a = sat(q_min, sb_min[2]);
    assign t_b = sat(q_max, sb_max);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sb_min[1]) begin
                o_tn <= T_LOW;
                o_tf <= T_HIGH;
            end else if (t_a > t_b) begin
                o_tn <= t_b;
                o_tf <= t_a;
            end else begin
                o_tn <= t_a;
                o_tf <= t_b;
            end
            o_miss <= sb_min[1] & ~sb_min[0];
        end
    end

endmodule

@@ sv/rbst_merge.sv @@
// ---------------------------------------------------------------------------
// rbst_merge
// combines the three lanes into entry, exit and the hit flag
// ---------------------------------------------------------------------------
module rbst_merge #(
    parameter int CB = rbst_pkg::COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_tn [3],
    input  logic signed [CB-1:0] i_tf [3],
    input  logic [2:0]           i_miss,
    output logic                 o_hit
);

    logic signed [CB-1:0] r_entry, r_exit, n_entry, n_exit;
    logic                 r_miss;

    always_comb begin
        n_entry = i_tn[0];
        n_exit  = i_tf[0];
        for (int k = 1; k < 3; k++) begin
            if (i_tn[k] > n_entry) n_entry = i_tn[k];
            if (i_tf[k] < n_exit)  n_exit  = i_tf[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
            r_exit  <= n_exit;
            r_miss  <= |i_miss;
        end
    end

    assign o_hit = !r_miss && (r_exit >= r_entry);

endmodule

@@ sv/ray_box_slab_test_core.sv @@
// ---------------------------------------------------------------------------
// ray_box_slab_test_core
// throughput: one request per cycle while the skid register is empty, set by the fully pipelined dividers
// one divider stage per quotient bit, three axis lanes in parallel
// reset: synchronous active low; box reset to empty, pipeline and output empty
// ---------------------------------------------------------------------------
module ray_box_slab_test_core #(
    parameter int COORD_BITS = rbst_pkg::COORD_BITS,
    parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hit
    output logic [7:0]                        m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbst_pkg::IDX_BITS-1:0]     i_cfg_index,
    input  logic [COORD_BITS-1:0]             i_cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int LAT = CB + FRAC_BITS + 3;

    logic signed [CB-1:0] r_bmin [3];
    logic signed [CB-1:0] r_bmax [3];
    logic signed [CB-1:0] r_org  [3];
    logic signed [CB-1:0] r_dir  [3];
    logic signed [CB-1:0] tn [3];
    logic signed [CB-1:0] tf [3];
    logic [2:0]           miss;
    logic [LAT-1:0]       r_vld;
    logic                 en, hit, pop, load;
    logic                 r_out_valid, r_out_hit, r_sk_valid, r_sk_hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_bmin[k] <= {1'b0, {(CB-1){1'b1}}};
                r_bmax[k] <= {1'b1, {(CB-1){1'b0}}};
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rbst_pkg::REG_MIN_X: r_bmin[0] <= i_cfg_data;
                rbst_pkg::REG_MIN_Y: r_bmin[1] <= i_cfg_data;
                rbst_pkg::REG_MIN_Z: r_bmin[2] <= i_cfg_data;
                rbst_pkg::REG_MAX_X: r_bmax[0] <= i_cfg_data;
                rbst_pkg::REG_MAX_Y: r_bmax[1] <= i_cfg_data;
                rbst_pkg::REG_MAX_Z: r_bmax[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !r_sk_valid;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= s_axis_tdata[k*CB +: CB];
                r_dir[k] <= s_axis_tdata[(k+3)*CB +: CB];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        rbst_lane #(.CB(CB), .FB(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_org  (r_org[k]),
            .i_dir  (r_dir[k]),
            .i_bmin (r_bmin[k]),
            .i_bmax (r_bmax[k]),
            .o_tn   (tn[k]),
            .o_tf   (tf[k]),
            .o_miss (miss[k])
        );
    end

    rbst_merge #(.CB(CB)) u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_tn   (tn),
        .i_tf   (tf),
        .i_miss (miss),
        .o_hit  (hit)
    );

    assign pop  = r_out_valid && m_axis_tready;
    assign load = en && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
            end
            if (pop && r_sk_valid) begin
                r_out_hit  <= r_sk_hit;
                r_sk_valid <= 1'b0;
            end else if (load && (!r_out_valid || pop)) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= hit;
            end else if (load) begin
                r_sk_valid <= 1'b1;
                r_sk_hit   <= hit;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_hit};

endmodule

@@ sv/rbst_checker.sv @@
// ---------------------------------------------------------------------------
// rbst_checker
// port level checks for the slab test core
// ---------------------------------------------------------------------------
module rbst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       o_cfg_ready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

    a_cfg: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port not ready");

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);
